FILE: hdl/spd_pkg.sv
`default_nettype none

package spd_pkg;

    localparam int NODE_W = 6;
    localparam int COST_W = 16;
    localparam int DIST_W = 22;
    localparam int NCFG_W = 7;

    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
    localparam logic [NCFG_W-1:0] NODE_COUNT_RST = 7'd64;

    typedef struct packed {
        logic [NODE_W-1:0] edge_from;
        logic [NODE_W-1:0] edge_to;
        logic [COST_W-1:0] edge_cost;
        logic              last_edge;
    } spd_in_t;

    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic              reachable;
        logic [DIST_W-1:0] distance;
        logic              last_node;
    } spd_out_t;

    typedef struct packed {
        logic [NODE_W-1:0] edge_from;
        logic [NODE_W-1:0] edge_to;
        logic [COST_W-1:0] edge_cost;
    } spd_edge_t;

    typedef struct packed {
        logic store;
        logic init;
        logic node_rst;
        logic scan_rd;
        logic emit_rd;
        logic mark;
        logic edge_rst;
        logic edge_rd;
        logic dist_rd;
        logic relax;
        logic edges_clr;
    } spd_cmd_t;

    typedef struct packed {
        logic node_last;
        logic found;
        logic edge_done;
    } spd_stat_t;

endpackage

`default_nettype wire

FILE: hdl/spd_ctrl.sv
`default_nettype none

module spd_ctrl
    import spd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      last_edge,
    input  wire spd_stat_t stat,
    output spd_cmd_t       cmd,
    output logic           busy
);

    typedef enum logic [3:0] {
        IDLE,
        INIT,
        SCAN_START,
        SCAN,
        SCAN_WAIT,
        SCAN_DONE,
        EDGE_RD,
        EDGE_DIST,
        EDGE_UPD,
        EMIT_START,
        EMIT,
        FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    cmd.store = 1'b1;
                    if (last_edge)
                    begin
                        state_next = INIT;
                    end
                end
            end
            INIT:
            begin
                cmd.init   = 1'b1;
                state_next = SCAN_START;
            end
            SCAN_START:
            begin
                cmd.node_rst = 1'b1;
                state_next   = SCAN;
            end
            SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.node_last)
                begin
                    state_next = SCAN_WAIT;
                end
            end
            SCAN_WAIT:
            begin
                state_next = SCAN_DONE;
            end
            SCAN_DONE:
            begin
                if (stat.found)
                begin
                    cmd.mark     = 1'b1;
                    cmd.edge_rst = 1'b1;
                    state_next   = EDGE_RD;
                end
                else
                begin
                    state_next = EMIT_START;
                end
            end
            EDGE_RD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = EDGE_DIST;
            end
            EDGE_DIST:
            begin
                cmd.dist_rd = 1'b1;
                state_next  = EDGE_UPD;
            end
            EDGE_UPD:
            begin
                cmd.relax = 1'b1;
                if (stat.edge_done)
                begin
                    state_next = SCAN_START;
                end
                else
                begin
                    state_next = EDGE_RD;
                end
            end
            EMIT_START:
            begin
                cmd.node_rst = 1'b1;
                state_next   = EMIT;
            end
            EMIT:
            begin
                cmd.emit_rd = 1'b1;
                if (stat.node_last)
                begin
                    state_next = FLUSH;
                end
            end
            FLUSH:
            begin
                cmd.edges_clr = 1'b1;
                state_next    = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    assign busy = (state_reg != IDLE);

endmodule

`default_nettype wire

FILE: hdl/spd_datapath.sv
`default_nettype none

module spd_datapath
    import spd_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spd_cmd_t          cmd,
    input  wire spd_in_t           edge_in,
    input  wire logic              cfg_we,
    input  wire logic [NCFG_W-1:0] cfg_data,
    output spd_stat_t              stat,
    output logic                   result_valid,
    output spd_out_t               result
);

    localparam int NIDX_W  = $clog2(MAX_NODES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int EADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam logic [NCFG_W-1:0] NMAX = NCFG_W'(MAX_NODES);

    spd_edge_t         edge_mem [MAX_EDGES];
    logic [DIST_W-1:0] dist_mem [MAX_NODES];

    logic [NCFG_W-1:0]    node_count_reg;
    logic [ECNT_W-1:0]    edge_total_reg;
    logic [MAX_NODES-1:0] fin_reg;
    logic [MAX_NODES-1:0] seen_reg;
    logic                 found_reg;
    logic                 scan_pend_reg;
    logic                 emit_pend_reg;

    logic [NIDX_W-1:0] node_cnt_reg;
    logic [ECNT_W-1:0] edge_cnt_reg;
    logic [NIDX_W-1:0] rd_idx_reg;
    logic              rd_last_reg;
    logic [NIDX_W-1:0] best_idx_reg;
    logic [DIST_W-1:0] best_dist_reg;
    spd_edge_t         eq_reg;
    logic [DIST_W-1:0] dq_reg;
    logic              sq_reg;
    logic              fq_reg;
    logic [NIDX_W-1:0] other_reg;
    logic [DIST_W:0]   sum_reg;
    logic              rel_reg;

    logic [NCFG_W-1:0] n_eff;
    logic [NCFG_W-1:0] n_m1;
    logic              node_last;
    logic [DIST_W-1:0] d_eff;
    logic              take;
    logic [NODE_W-1:0] v6;
    logic              hit_a;
    logic              hit_b;
    logic              va;
    logic              vb;
    logic [NODE_W-1:0] other6;
    logic              rel_next;
    logic [DIST_W:0]   sum_next;
    logic [NIDX_W-1:0] rd_addr;
    logic              relax_hit;
    logic              dist_we;
    logic [NIDX_W-1:0] dist_waddr;
    logic [DIST_W-1:0] dist_wdata;
    logic              edge_we;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = NCFG_W'(1);
        end
        else if (node_count_reg > NMAX)
        begin
            n_eff = NMAX;
        end
        else
        begin
            n_eff = node_count_reg;
        end
    end

    assign n_m1      = n_eff - NCFG_W'(1);
    assign node_last = (NCFG_W'(node_cnt_reg) == n_m1);

    // distance as seen through the valid bits
    assign d_eff = sq_reg ? dq_reg : DIST_INF;
    assign take  = !fq_reg && (!found_reg || (d_eff < best_dist_reg));

    assign v6       = NODE_W'(best_idx_reg);
    assign hit_a    = (eq_reg.edge_from == v6);
    assign hit_b    = (eq_reg.edge_to == v6);
    assign va       = ({1'b0, eq_reg.edge_from} < n_eff);
    assign vb       = ({1'b0, eq_reg.edge_to} < n_eff);
    assign other6   = hit_a ? eq_reg.edge_to : eq_reg.edge_from;
    assign rel_next = va && vb && (hit_a || hit_b);
    assign sum_next = {1'b0, best_dist_reg} + (DIST_W+1)'(eq_reg.edge_cost);

    assign rd_addr = cmd.dist_rd ? other6[NIDX_W-1:0] : node_cnt_reg;

    assign relax_hit = cmd.relax && rel_reg && (sum_reg < {1'b0, DIST_INF})
                       && (sum_reg < {1'b0, d_eff});
    assign dist_we    = cmd.init || relax_hit;
    assign dist_waddr = cmd.init ? '0 : other_reg;
    assign dist_wdata = cmd.init ? '0 : sum_reg[DIST_W-1:0];

    assign edge_we = cmd.store && (edge_total_reg < ECNT_W'(MAX_EDGES));

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_total_reg[EADDR_W-1:0]] <= '{edge_from: edge_in.edge_from,
                                                      edge_to:   edge_in.edge_to,
                                                      edge_cost: edge_in.edge_cost};
        end
        if (cmd.edge_rd)
        begin
            eq_reg <= edge_mem[edge_cnt_reg[EADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dq_reg <= dist_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            edge_total_reg <= '0;
            fin_reg        <= '0;
            seen_reg       <= '0;
            found_reg      <= 1'b0;
            scan_pend_reg  <= 1'b0;
            emit_pend_reg  <= 1'b0;
        end
        else
        begin
            scan_pend_reg <= cmd.scan_rd;
            emit_pend_reg <= cmd.emit_rd;
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
            if (cmd.edges_clr)
            begin
                edge_total_reg <= '0;
            end
            else if (edge_we)
            begin
                edge_total_reg <= edge_total_reg + ECNT_W'(1);
            end
            if (cmd.init)
            begin
                fin_reg  <= '0;
                seen_reg <= MAX_NODES'(1);
            end
            else
            begin
                if (cmd.mark)
                begin
                    fin_reg[best_idx_reg] <= 1'b1;
                end
                if (relax_hit)
                begin
                    seen_reg[other_reg] <= 1'b1;
                end
            end
            if (cmd.node_rst)
            begin
                found_reg <= 1'b0;
            end
            else if (scan_pend_reg && take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= seen_reg[rd_addr];
        fq_reg <= fin_reg[rd_addr];
        if (cmd.node_rst)
        begin
            node_cnt_reg <= '0;
        end
        else if (cmd.scan_rd || cmd.emit_rd)
        begin
            node_cnt_reg <= node_cnt_reg + NIDX_W'(1);
            rd_idx_reg   <= node_cnt_reg;
            rd_last_reg  <= node_last;
        end
        if (cmd.edge_rst)
        begin
            edge_cnt_reg <= '0;
        end
        else if (cmd.edge_rd)
        begin
            edge_cnt_reg <= edge_cnt_reg + ECNT_W'(1);
        end
        if (scan_pend_reg && take)
        begin
            best_idx_reg  <= rd_idx_reg;
            best_dist_reg <= d_eff;
        end
        if (cmd.dist_rd)
        begin
            other_reg <= other6[NIDX_W-1:0];
            sum_reg   <= sum_next;
            rel_reg   <= rel_next;
        end
    end

    assign stat.node_last = node_last;
    assign stat.found     = found_reg;
    assign stat.edge_done = (edge_cnt_reg == edge_total_reg);

    assign result_valid      = emit_pend_reg;
    assign result.node_index = NODE_W'(rd_idx_reg);
    assign result.reachable  = (d_eff != DIST_INF);
    assign result.distance   = d_eff;
    assign result.last_node  = rd_last_reg;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= ECNT_W'(MAX_EDGES))
        else $error("edge count beyond store depth");

    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(cmd.emit_rd))
        else $error("result strobe without a read");

    a_mark_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark |-> !fin_reg[best_idx_reg])
        else $error("node finished twice");

    a_relax_valid: assert property (@(posedge clk) disable iff (!rst_n)
        relax_hit |-> (NCFG_W'(other_reg) < n_eff))
        else $error("relax write outside node range");
`endif

endmodule

`default_nettype wire

FILE: hdl/shortest_path_distances_unit.sv
// channel   | signals                          | handshake
// ----------+----------------------------------+---------------------------------
// edge in   | start, busy, edge_in             | word taken when start && !busy
// result    | result_valid, result             | one-cycle strobe, no back-pressure
// config    | cfg_valid, cfg_ready, cfg_data   | written when cfg_valid && cfg_ready
//
// an edge word without last_edge is stored while the store has room; busy stays low
// a word with last_edge starts the solve: an init step, then n + 1 node scans,
// the first n each followed by a pass over every stored edge
// then the n results follow one per cycle; busy drops after the last
// the receiver cannot stall, so nothing holds up the solve or the results
// reset clears the edge count and node_count returns to 64
`default_nettype none

module shortest_path_distances_unit
    import spd_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire spd_in_t           edge_in,
    output logic                   result_valid,
    output spd_out_t               result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [NCFG_W-1:0] cfg_data
);

    spd_cmd_t  cmd;
    spd_stat_t stat;

    assign cfg_ready = !busy;

    spd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_edge (edge_in.last_edge),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    spd_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .edge_in      (edge_in),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import spd_pkg::*;

    localparam int NODE_SLOTS  = 64;
    localparam int EDGE_SLOTS  = 256;
    localparam int STALL_LIMIT = 250000;

    class path_scoreboard;
        spd_edge_t         graph_edges[$];
        spd_out_t          expected_dist[$];
        logic [NCFG_W-1:0] node_count;
        int                fail_count;

        function new();
            node_count = NODE_COUNT_RST;
            fail_count = 0;
        endfunction

        function int active_nodes();
            if (node_count == 0)
                return 1;
            if (node_count > NODE_SLOTS)
                return NODE_SLOTS;
            return int'(node_count);
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= 10)
                $display("%s", msg);
        endfunction

        function void note_edge(spd_in_t w);
            logic [DIST_W-1:0] node_dist [NODE_SLOTS];
            bit                done [NODE_SLOTS];
            int                n;
            int                v;
            int                src;
            int                dst;
            bit                found;
            logic [31:0]       sum;
            spd_out_t          r;
            if (graph_edges.size() < EDGE_SLOTS)
                graph_edges.insert(graph_edges.size(),
                                   '{w.edge_from, w.edge_to, w.edge_cost});
            if (!w.last_edge)
                return;
            n = active_nodes();
            for (int i = 0; i < NODE_SLOTS; i++)
            begin
                node_dist[i] = DIST_INF;
                done[i] = 1'b0;
            end
            node_dist[0] = '0;
            found = 1'b1;
            while (found)
            begin
                found = 1'b0;
                v = 0;
                for (int i = 0; i < n; i++)
                    if (!done[i] && (!found || node_dist[i] < node_dist[v]))
                    begin
                        v = i;
                        found = 1'b1;
                    end
                if (found)
                begin
                    done[v] = 1'b1;
                    foreach (graph_edges[k])
                    begin
                        if (graph_edges[k].edge_from < n && graph_edges[k].edge_to < n)
                        begin
                            for (int side = 0; side < 2; side++)
                            begin
                                src = (side == 0) ? graph_edges[k].edge_from
                                                  : graph_edges[k].edge_to;
                                dst = (side == 0) ? graph_edges[k].edge_to
                                                  : graph_edges[k].edge_from;
                                if (src == v)
                                begin
                                    sum = 32'(node_dist[src]) + 32'(graph_edges[k].edge_cost);
                                    if (sum < 32'(DIST_INF) && sum < 32'(node_dist[dst]))
                                        node_dist[dst] = sum[DIST_W-1:0];
                                end
                            end
                        end
                    end
                end
            end
            for (int i = 0; i < n; i++)
            begin
                r.node_index = 6'(i);
                r.reachable  = (node_dist[i] != DIST_INF);
                r.distance   = node_dist[i];
                r.last_node  = (i == n - 1);
                expected_dist.insert(expected_dist.size(), r);
            end
            graph_edges.delete();
        endfunction

        function void check_distance(spd_out_t got);
            spd_out_t want;
            if (expected_dist.size() == 0)
            begin
                flag($sformatf("unexpected result: node %0d reach %0b dist %0d last %0b",
                               got.node_index, got.reachable, got.distance, got.last_node));
                return;
            end
            want = expected_dist.pop_front();
            if (got.node_index !== want.node_index || got.reachable !== want.reachable ||
                got.distance !== want.distance || got.last_node !== want.last_node)
                flag($sformatf({"mismatch: expected node %0d reach %0b dist %0d last %0b,",
                                " got node %0d reach %0b dist %0d last %0b"},
                               want.node_index, want.reachable, want.distance,
                               want.last_node, got.node_index, got.reachable,
                               got.distance, got.last_node));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    spd_in_t           edge_in = '0;
    logic              result_valid;
    spd_out_t          result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [NCFG_W-1:0] cfg_data = '0;

    path_scoreboard sb;
    int             gap_pct = 0;
    int             idle_cycles = 0;

    shortest_path_distances_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .edge_in      (edge_in),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            sb.check_distance(result);
    end

    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || result_valid === 1'b1 ||
            (cfg_valid && cfg_ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic spd_in_t edge_word(int f, int t, int c, bit l);
        spd_in_t w;
        w.edge_from = 6'(f);
        w.edge_to   = 6'(t);
        w.edge_cost = 16'(c);
        w.last_edge = l;
        return w;
    endfunction

    function automatic int pick_node(int n);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 63);
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, n - 1);
    endfunction

    task automatic send_edge(spd_in_t w);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        edge_in <= w;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_edge(w);
    endtask

    // hold off until every distance word is back and the block is idle
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_dist.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_node_count(logic [NCFG_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        sb.node_count = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_graph(int count);
        spd_in_t w;
        int      n;
        n = sb.active_nodes();
        for (int k = 0; k < count; k++)
        begin
            w.edge_from = 6'(pick_node(n));
            w.edge_to   = 6'(pick_node(n));
            case ($urandom_range(0, 7))
                0:       w.edge_cost = '0;
                1:       w.edge_cost = '1;
                2, 3:    w.edge_cost = 16'($urandom_range(0, 65535));
                default: w.edge_cost = 16'($urandom_range(0, 20));
            endcase
            w.last_edge = (k == count - 1);
            send_edge(w);
        end
    endtask

    initial
    begin
        logic [NCFG_W-1:0] seg_cfg [6];
        int                left;
        int                m;
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        gap_pct = 9;

        // node count from reset, ties, self loop, unreached pair
        send_edge(edge_word(0, 1, 0, 0));
        send_edge(edge_word(1, 2, 65535, 0));
        send_edge(edge_word(0, 2, 65535, 0));
        send_edge(edge_word(2, 63, 1, 0));
        send_edge(edge_word(63, 63, 7, 0));
        send_edge(edge_word(5, 6, 3, 1));
        settle();

        // zero acts as one node
        write_node_count(7'd0);
        send_edge(edge_word(0, 1, 5, 0));
        send_edge(edge_word(0, 0, 12, 1));
        settle();

        // above range acts as full size
        write_node_count(7'd127);
        send_edge(edge_word(0, 63, 65535, 0));
        send_edge(edge_word(63, 62, 65535, 0));
        send_edge(edge_word(62, 61, 43690, 0));
        send_edge(edge_word(0, 61, 21845, 1));
        settle();

        // endpoint out of range is ignored
        write_node_count(7'd3);
        send_edge(edge_word(5, 0, 1, 0));
        send_edge(edge_word(0, 1, 2, 0));
        send_edge(edge_word(0, 2, 2, 0));
        send_edge(edge_word(2, 1, 0, 0));
        send_edge(edge_word(1, 2, 0, 1));
        settle();

        write_node_count(7'd2);
        send_edge(edge_word(1, 0, 65535, 1));
        settle();

        seg_cfg[0] = 7'd64;
        seg_cfg[1] = 7'($urandom_range(2, 12));
        seg_cfg[2] = 7'd1;
        seg_cfg[3] = 7'($urandom_range(20, 63));
        seg_cfg[4] = 7'd127;
        seg_cfg[5] = 7'($urandom_range(3, 8));
        for (int seg = 0; seg < 6; seg++)
        begin
            write_node_count(seg_cfg[seg]);
            gap_pct = (seg < 2) ? 9 : (seg < 4) ? 48 : 0;
            left = 2;
            while (left > 0)
            begin
                m = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 10);
                if (m > left)
                    m = left;
                random_graph(m);
                left -= m;
                if ($urandom_range(0, 5) == 0)
                    settle();
            end
            // overfill the edge store on a small graph
            if (seg == 5)
                random_graph(EDGE_SLOTS + 1);
            settle();
        end

        repeat (20) @(posedge clk);
        if (sb.expected_dist.size() != 0)
            sb.flag($sformatf("%0d distance words never arrived", sb.expected_dist.size()));
        if (sb.fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: files.f
hdl/spd_pkg.sv
hdl/spd_ctrl.sv
hdl/spd_datapath.sv
hdl/shortest_path_distances_unit.sv
bench/testbench.sv
